>>> hdl/cbe_pkg.sv
// Shared types, constants and helpers of the cubic Bezier easing core.
// No dependencies; used by cbe_mul, cbe_div and cubic_bezier_easing_core.
package cbe_pkg;

    localparam int SAMPLE_POINTS = 11;
    localparam int NEWTON_STEPS  = 4;
    localparam int FRAC_BITS     = 16;

    localparam int ONE_I  = 1 << FRAC_BITS;
    localparam int HALF_I = 1 << (FRAC_BITS - 1);
    localparam int T_W    = FRAC_BITS + 1;
    localparam int W_D    = FRAC_BITS + 12;
    localparam int NUM_W  = W_D + FRAC_BITS;
    localparam int IDX_W  = $clog2(SAMPLE_POINTS);
    localparam int K_W    = $clog2(NEWTON_STEPS + 1);
    localparam int NEAR   = (ONE_I + 9999) / 10000;
    localparam int PX_W   = 17;
    localparam int PY_W   = 19;
    localparam int OUT_LO = -131072;
    localparam int OUT_HI = 196608;

    // first guess t = (idx*ONE + d + half) / (SAMPLE_POINTS-1) by reciprocal multiply
    localparam int     TG_SH  = FRAC_BITS + 12;
    localparam int     TG_NW  = FRAC_BITS + 6;
    localparam int     TG_PW  = TG_NW + TG_SH;
    localparam longint TG_MUL = ((longint'(1) << TG_SH) + SAMPLE_POINTS - 2)
                              / (SAMPLE_POINTS - 1);

    typedef logic signed [W_D-1:0] t_val;
    typedef logic [T_W-1:0]        t_frac;
    typedef t_frac                 t_tab [SAMPLE_POINTS];

    typedef enum logic [1:0] {
        REG_C1X = 2'd0,
        REG_C1Y = 2'd1,
        REG_C2X = 2'd2,
        REG_C2Y = 2'd3
    } t_reg;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [W_D-1:0]   den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
    } t_div_rsp;

    function automatic t_tab sample_table();
        t_tab tab;
        for (int i = 0; i < SAMPLE_POINTS; i++) begin
            tab[i] = T_W'((i * ONE_I + (SAMPLE_POINTS - 1) / 2) / (SAMPLE_POINTS - 1));
        end
        return tab;
    endfunction

    localparam t_tab SAMPLE_T = sample_table();

    function automatic logic [W_D-1:0] mag(t_val v);
        return v[W_D-1] ? W_D'(-v) : W_D'(v);
    endfunction

endpackage

>>> hdl/cubic_bezier_easing_core.sv
// Cubic Bezier easing core: sequencer around one multiplier and one divider.
// Depends on cbe_pkg, cbe_mul and cbe_div.
//
// Usage:
//   Input word: i_progress (Q1.16) on i_valid/o_ready. Result word:
//   o_eased (signed Q.16) and o_ok on o_valid/i_ready.
//   Control points are written through i_cfg_we/i_cfg_idx/i_cfg_data while
//   the core is idle; reset loads the linear curve (0,0),(1,1).
//   One word is processed at a time; o_ready is low from acceptance until
//   the result has been taken, and rises in the cycle after that.
//   Invalid controls, end points and the linear curve go straight to the
//   output register. Otherwise the core searches the sampled table point by
//   point (up to 10 points), runs a division of the NUM_W-bit (44-bit)
//   numerator for the interpolation fraction when the segment rises, makes
//   the first guess, evaluates the slope, runs up to 4 Newton steps (curve,
//   division, slope; no slope in the last) and evaluates the y curve. The
//   bit-serial divider takes most of the processing time.
//   When the receiver stalls, the result is held in the output register
//   and no new word is accepted until it is taken.
module cubic_bezier_easing_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [cbe_pkg::PX_W-1:0]              i_progress,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [cbe_pkg::PY_W-1:0]       o_eased,
    output logic                                  o_ok,
    input  logic                                  i_cfg_we,
    input  logic [1:0]                            i_cfg_idx,
    input  logic [cbe_pkg::PY_W-1:0]              i_cfg_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_CV1, S_CV2, S_CV3, S_CV4, S_SL1, S_SL2, S_SL3, S_SL4,
        S_DIVD, S_TGO, S_DIVN, S_OUT
    } t_state;

    typedef enum logic [1:0] {M_SAMP, M_NEWT, M_YEV} t_mode;

    t_state r_state;
    t_mode  r_mode;

    logic [cbe_pkg::PX_W-1:0]        r_c1x, r_c2x;
    logic signed [cbe_pkg::PY_W-1:0] r_c1y, r_c2y;

    cbe_pkg::t_val  r_x, r_prev, r_s, r_acc;
    cbe_pkg::t_val  r_ax, r_bx, r_cx, r_ay, r_by, r_cy;
    cbe_pkg::t_frac r_t, r_d;
    logic [cbe_pkg::IDX_W-1:0] r_idx;
    logic [cbe_pkg::K_W-1:0]   r_k;
    logic           r_first, r_dneg;
    logic signed [cbe_pkg::PY_W-1:0] r_eased;
    logic           r_ok, r_ovalid;
    logic           r_dstart;
    logic [cbe_pkg::NUM_W-1:0] r_dnum;
    logic [cbe_pkg::W_D-1:0]   r_dden;

    cbe_pkg::t_val     mul_a, prod;
    cbe_pkg::t_val     ca, cb, cc;
    cbe_pkg::t_div_req div_req;
    cbe_pkg::t_div_rsp div_rsp;

    cbe_pkg::t_val p1x, p2x, p1y, p2y, xin;
    logic          bad_ctrl, near0, near1, lin;
    cbe_pkg::t_val numv, denv, fv, sv, tn, dx1;
    logic [cbe_pkg::NUM_W-1:0] qs;
    logic [cbe_pkg::TG_NW-1:0] tg_num;
    logic [cbe_pkg::TG_PW-1:0] tg_prod;
    cbe_pkg::t_frac            tg_q;

    function automatic cbe_pkg::t_val coef_a(cbe_pkg::t_val p1, cbe_pkg::t_val p2);
        return cbe_pkg::t_val'(cbe_pkg::ONE_I) - (p2 <<< 1) - p2 + (p1 <<< 1) + p1;
    endfunction

    function automatic cbe_pkg::t_val coef_b(cbe_pkg::t_val p1, cbe_pkg::t_val p2);
        return (p2 <<< 1) + p2 - (p1 <<< 2) - (p1 <<< 1);
    endfunction

    function automatic cbe_pkg::t_val coef_c(cbe_pkg::t_val p1);
        return (p1 <<< 1) + p1;
    endfunction

    cbe_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_t    (r_t),
        .o_prod (prod)
    );

    cbe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign div_req.start = r_dstart;
    assign div_req.num   = r_dnum;
    assign div_req.den   = r_dden;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1x <= '0;
            r_c1y <= '0;
            r_c2x <= cbe_pkg::PX_W'(cbe_pkg::ONE_I);
            r_c2y <= cbe_pkg::PY_W'(cbe_pkg::ONE_I);
        end else if (i_cfg_we) begin
            unique case (cbe_pkg::t_reg'(i_cfg_idx))
                cbe_pkg::REG_C1X: r_c1x <= i_cfg_data[cbe_pkg::PX_W-1:0];
                cbe_pkg::REG_C1Y: r_c1y <= i_cfg_data;
                cbe_pkg::REG_C2X: r_c2x <= i_cfg_data[cbe_pkg::PX_W-1:0];
                cbe_pkg::REG_C2Y: r_c2y <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        p1x = cbe_pkg::t_val'($signed({1'b0, r_c1x}));
        p2x = cbe_pkg::t_val'($signed({1'b0, r_c2x}));
        p1y = cbe_pkg::t_val'(r_c1y);
        p2y = cbe_pkg::t_val'(r_c2y);
        xin = cbe_pkg::t_val'($signed({1'b0, i_progress}));
        dx1 = xin - cbe_pkg::t_val'(cbe_pkg::ONE_I);
        bad_ctrl = (p1x > cbe_pkg::t_val'(cbe_pkg::ONE_I))
                || (p2x > cbe_pkg::t_val'(cbe_pkg::ONE_I));
        near0 = xin < cbe_pkg::t_val'(cbe_pkg::NEAR);
        near1 = cbe_pkg::mag(dx1) < cbe_pkg::W_D'(cbe_pkg::NEAR);
        lin   = (p1x == p1y) && (p2x == p2y);

        ca = (r_mode == M_YEV) ? r_ay : r_ax;
        cb = (r_mode == M_YEV) ? r_by : r_bx;
        cc = (r_mode == M_YEV) ? r_cy : r_cx;

        unique case (r_state)
            S_CV1:   mul_a = ca;
            S_CV2:   mul_a = prod + cb;
            S_CV3:   mul_a = prod + cc;
            S_SL1:   mul_a = r_ax;
            S_SL2:   mul_a = prod;
            S_SL3:   mul_a = r_bx;
            default: mul_a = ca;
        endcase

        numv = r_x - r_prev;
        denv = prod - r_prev;
        fv   = prod - r_x;
        sv   = r_acc + (prod <<< 1) + r_cx;
        qs   = (div_rsp.quo > cbe_pkg::NUM_W'(2 * cbe_pkg::ONE_I))
             ? cbe_pkg::NUM_W'(2 * cbe_pkg::ONE_I) : div_rsp.quo;
        tn   = r_dneg ? cbe_pkg::t_val'(r_t) + cbe_pkg::t_val'(qs)
                      : cbe_pkg::t_val'(r_t) - cbe_pkg::t_val'(qs);

        tg_num  = (cbe_pkg::TG_NW'(r_idx) << cbe_pkg::FRAC_BITS)
                + cbe_pkg::TG_NW'(r_d)
                + cbe_pkg::TG_NW'((cbe_pkg::SAMPLE_POINTS - 1) / 2);
        tg_prod = cbe_pkg::TG_PW'(tg_num) * cbe_pkg::TG_PW'(cbe_pkg::TG_MUL);
        tg_q    = tg_prod[cbe_pkg::TG_SH +: cbe_pkg::T_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= M_SAMP;
            r_ovalid <= 1'b0;
            r_dstart <= 1'b0;
            r_first  <= 1'b0;
            r_k      <= '0;
            r_idx    <= '0;
        end else begin
            r_dstart <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_x   <= xin;
                        r_ax  <= coef_a(p1x, p2x);
                        r_bx  <= coef_b(p1x, p2x);
                        r_cx  <= coef_c(p1x);
                        r_ay  <= coef_a(p1y, p2y);
                        r_by  <= coef_b(p1y, p2y);
                        r_cy  <= coef_c(p1y);
                        r_k   <= '0;
                        r_ok  <= !bad_ctrl;
                        if (bad_ctrl || near0) begin
                            r_eased  <= '0;
                            r_ovalid <= 1'b1;
                            r_state  <= S_OUT;
                        end else if (near1) begin
                            r_eased  <= cbe_pkg::PY_W'(cbe_pkg::ONE_I);
                            r_ovalid <= 1'b1;
                            r_state  <= S_OUT;
                        end else if (lin) begin
                            r_eased  <= cbe_pkg::PY_W'(xin);
                            r_ovalid <= 1'b1;
                            r_state  <= S_OUT;
                        end else begin
                            r_mode  <= M_SAMP;
                            r_idx   <= cbe_pkg::IDX_W'(1);
                            r_prev  <= '0;
                            r_t     <= cbe_pkg::SAMPLE_T[cbe_pkg::IDX_W'(1)];
                            r_state <= S_CV1;
                        end
                    end
                end
                S_CV1: r_state <= S_CV2;
                S_CV2: r_state <= S_CV3;
                S_CV3: r_state <= S_CV4;
                S_CV4: begin
                    unique case (r_mode)
                        M_SAMP: begin
                            if (r_idx < cbe_pkg::IDX_W'(cbe_pkg::SAMPLE_POINTS - 1)
                                && prod <= r_x) begin
                                r_prev  <= prod;
                                r_idx   <= r_idx + 1'b1;
                                r_t     <= cbe_pkg::SAMPLE_T[r_idx + 1'b1];
                                r_state <= S_CV1;
                            end else begin
                                r_idx <= r_idx - 1'b1;
                                if (denv <= 0 || numv < 0) begin
                                    r_d     <= '0;
                                    r_state <= S_TGO;
                                end else begin
                                    r_dnum   <= (cbe_pkg::NUM_W'(numv) << cbe_pkg::FRAC_BITS)
                                              + cbe_pkg::NUM_W'(denv >>> 1);
                                    r_dden   <= cbe_pkg::W_D'(denv);
                                    r_dstart <= 1'b1;
                                    r_state  <= S_DIVD;
                                end
                            end
                        end
                        M_NEWT: begin
                            r_dnum   <= (cbe_pkg::NUM_W'(cbe_pkg::mag(fv)) << cbe_pkg::FRAC_BITS)
                                      + cbe_pkg::NUM_W'(cbe_pkg::mag(r_s) >> 1);
                            r_dden   <= cbe_pkg::mag(r_s);
                            r_dneg   <= fv[cbe_pkg::W_D-1] ^ r_s[cbe_pkg::W_D-1];
                            r_dstart <= 1'b1;
                            r_state  <= S_DIVN;
                        end
                        default: begin
                            if (prod < cbe_pkg::t_val'(cbe_pkg::OUT_LO)) begin
                                r_eased <= cbe_pkg::PY_W'(cbe_pkg::OUT_LO);
                            end else if (prod > cbe_pkg::t_val'(cbe_pkg::OUT_HI)) begin
                                r_eased <= cbe_pkg::PY_W'(cbe_pkg::OUT_HI);
                            end else begin
                                r_eased <= prod[cbe_pkg::PY_W-1:0];
                            end
                            r_ovalid <= 1'b1;
                            r_state  <= S_OUT;
                        end
                    endcase
                end
                S_DIVD: begin
                    if (div_rsp.done) begin
                        r_d <= (div_rsp.quo > cbe_pkg::NUM_W'(cbe_pkg::ONE_I))
                             ? cbe_pkg::T_W'(cbe_pkg::ONE_I)
                             : div_rsp.quo[cbe_pkg::T_W-1:0];
                        r_state <= S_TGO;
                    end
                end
                S_TGO: begin
                    r_t     <= (tg_q > cbe_pkg::T_W'(cbe_pkg::ONE_I))
                             ? cbe_pkg::T_W'(cbe_pkg::ONE_I) : tg_q;
                    r_first <= 1'b1;
                    r_state <= S_SL1;
                end
                S_SL1: r_state <= S_SL2;
                S_SL2: r_state <= S_SL3;
                S_SL3: begin
                    r_acc   <= (prod <<< 1) + prod;
                    r_state <= S_SL4;
                end
                S_SL4: begin
                    r_s     <= sv;
                    r_first <= 1'b0;
                    r_state <= S_CV1;
                    if (r_first ? (sv >= cbe_pkg::t_val'(cbe_pkg::NEAR))
                                : (cbe_pkg::mag(sv) >= cbe_pkg::W_D'(cbe_pkg::NEAR))) begin
                        r_mode <= M_NEWT;
                    end else begin
                        r_mode <= M_YEV;
                    end
                end
                S_DIVN: begin
                    if (div_rsp.done) begin
                        if (tn < 0) begin
                            r_t <= '0;
                        end else if (tn > cbe_pkg::t_val'(cbe_pkg::ONE_I)) begin
                            r_t <= cbe_pkg::T_W'(cbe_pkg::ONE_I);
                        end else begin
                            r_t <= tn[cbe_pkg::T_W-1:0];
                        end
                        if (r_k == cbe_pkg::K_W'(cbe_pkg::NEWTON_STEPS - 1)) begin
                            r_mode  <= M_YEV;
                            r_state <= S_CV1;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_SL1;
                        end
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_ovalid <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_eased = r_eased;
    assign o_ok    = r_ok;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input accepted while a result is pending");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("core ready right after accepting a word");
    a_bad_ctrl_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_eased == '0))
        else $error("invalid controls must give zero");
    a_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SL1) |-> (r_t <= cbe_pkg::T_W'(cbe_pkg::ONE_I)))
        else $error("curve parameter out of range");
`endif
endmodule

>>> hdl/cbe_mul.sv
// Shared fixed point multiplier: value times curve parameter, rounded half
// away from zero, registered output. Depends on cbe_pkg.
module cbe_mul (
    input  logic          i_clk,
    input  cbe_pkg::t_val  i_a,
    input  cbe_pkg::t_frac i_t,
    output cbe_pkg::t_val  o_prod
);
    localparam int PW = cbe_pkg::W_D + cbe_pkg::T_W;

    logic [cbe_pkg::W_D-1:0] mag_a;
    logic [PW-1:0]           prod_full;
    logic [cbe_pkg::W_D-1:0] q;
    cbe_pkg::t_val           n_prod;
    cbe_pkg::t_val           r_prod;

    always_comb begin
        mag_a     = cbe_pkg::mag(i_a);
        prod_full = PW'(mag_a) * PW'(i_t) + PW'(cbe_pkg::HALF_I);
        q         = prod_full[cbe_pkg::FRAC_BITS +: cbe_pkg::W_D];
        n_prod    = i_a[cbe_pkg::W_D-1] ? -cbe_pkg::t_val'(q) : cbe_pkg::t_val'(q);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;
endmodule

>>> hdl/cbe_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on cbe_pkg for widths and request/response structs.
module cbe_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cbe_pkg::t_div_req i_req,
    output cbe_pkg::t_div_rsp o_rsp
);
    localparam int CW = $clog2(cbe_pkg::NUM_W + 1);

    logic                        r_busy;
    logic                        r_done;
    logic [CW-1:0]               r_cnt;
    logic [cbe_pkg::W_D:0]       r_rem;
    logic [cbe_pkg::NUM_W-1:0]   r_quo;
    logic [cbe_pkg::W_D-1:0]     r_den;
    logic [cbe_pkg::W_D:0]       rem_sh;
    logic [cbe_pkg::W_D:0]       rem_sub;
    logic                        ge;

    always_comb begin
        rem_sh  = {r_rem[cbe_pkg::W_D-1:0], r_quo[cbe_pkg::NUM_W-1]};
        ge      = rem_sh >= {1'b0, r_den};
        rem_sub = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.num;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_rem <= ge ? rem_sub : rem_sh;
                r_quo <= {r_quo[cbe_pkg::NUM_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(cbe_pkg::NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule

>>> dv/cubic_bezier_easing_core_test.sv
// Testbench for cubic_bezier_easing_core: directed and random progress words
// checked against a fixed-point easing predictor kept in the bench.
// Depends on cbe_pkg and the core RTL.
module cubic_bezier_easing_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE_L    = 65536;
    localparam int     WD_LIMIT = 20000;

    typedef struct packed {
        logic signed [cbe_pkg::PY_W-1:0] eased;
        logic                            ok;
    } t_eased_word;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_ready;
    logic [cbe_pkg::PX_W-1:0]        i_progress = '0;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    logic signed [cbe_pkg::PY_W-1:0] o_eased;
    logic                            o_ok;
    logic                            i_cfg_we = 1'b0;
    logic [1:0]                      i_cfg_idx = '0;
    logic [cbe_pkg::PY_W-1:0]        i_cfg_data = '0;

    longint      ctl_c1x, ctl_c1y, ctl_c2x, ctl_c2y;
    t_eased_word pending_eased[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_len = 0;
    int          hold_seq = 0;
    int          hold_seen = 0;
    int          hold_cycles = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;

    cubic_bezier_easing_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_progress (i_progress),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_eased    (o_eased),
        .o_ok       (o_ok),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint q_mul(longint a, longint b);
        longint p;
        p = ((a < 0 ? -a : a) * (b < 0 ? -b : b) + 32768) >>> 16;
        return ((a < 0) != (b < 0)) ? -p : p;
    endfunction

    function automatic longint q_div(longint n, longint d);
        longint ud, q;
        ud = d < 0 ? -d : d;
        if (ud == 0) begin
            return 0;
        end
        q = (((n < 0 ? -n : n) << 16) + ud / 2) / ud;
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint bez_pos(longint t, longint p1, longint p2);
        longint a, b, c;
        a = ONE_L - 3 * p2 + 3 * p1;
        b = 3 * p2 - 6 * p1;
        c = 3 * p1;
        return q_mul(q_mul(q_mul(a, t) + b, t) + c, t);
    endfunction

    function automatic longint bez_slope(longint t, longint p1, longint p2);
        longint a, b, c;
        a = ONE_L - 3 * p2 + 3 * p1;
        b = 3 * p2 - 6 * p1;
        c = 3 * p1;
        return 3 * q_mul(q_mul(a, t), t) + 2 * q_mul(b, t) + c;
    endfunction

    function automatic longint solve_y(longint x);
        longint smp[cbe_pkg::SAMPLE_POINTS];
        longint num, den, d, t, s, dx;
        int     c;
        if (x * 10000 < ONE_L) begin
            return 0;
        end
        dx = x - ONE_L;
        if ((dx < 0 ? -dx : dx) * 10000 < ONE_L) begin
            return ONE_L;
        end
        if (ctl_c1x == ctl_c1y && ctl_c2x == ctl_c2y) begin
            return x;
        end
        for (int i = 0; i < cbe_pkg::SAMPLE_POINTS; i++) begin
            smp[i] = bez_pos((i * ONE_L + (cbe_pkg::SAMPLE_POINTS - 1) / 2)
                             / (cbe_pkg::SAMPLE_POINTS - 1), ctl_c1x, ctl_c2x);
        end
        c = 1;
        while (c < cbe_pkg::SAMPLE_POINTS - 1 && smp[c] <= x) begin
            c++;
        end
        c--;
        num = x - smp[c];
        den = smp[c+1] - smp[c];
        d = (den <= 0) ? 0 : clip(q_div(num, den), 0, ONE_L);
        t = (c * ONE_L + d + (cbe_pkg::SAMPLE_POINTS - 1) / 2) / (cbe_pkg::SAMPLE_POINTS - 1);
        t = clip(t, 0, ONE_L);
        s = bez_slope(t, ctl_c1x, ctl_c2x);
        if (s * 10000 >= ONE_L) begin
            for (int i = 0; i < cbe_pkg::NEWTON_STEPS; i++) begin
                s = bez_slope(t, ctl_c1x, ctl_c2x);
                if ((s < 0 ? -s : s) * 10000 < ONE_L) begin
                    break;
                end
                t -= q_div(bez_pos(t, ctl_c1x, ctl_c2x) - x, s);
                t = clip(t, 0, ONE_L);
            end
        end
        return bez_pos(t, ctl_c1y, ctl_c2y);
    endfunction

    function automatic t_eased_word predict_eased(logic [cbe_pkg::PX_W-1:0] prog);
        t_eased_word w;
        if (ctl_c1x > ONE_L || ctl_c2x > ONE_L) begin
            w.eased = '0;
            w.ok    = 1'b0;
        end else begin
            w.eased = cbe_pkg::PY_W'(clip(solve_y(longint'(prog)),
                                          cbe_pkg::OUT_LO, cbe_pkg::OUT_HI));
            w.ok    = 1'b1;
        end
        return w;
    endfunction

    // scoreboard and watchdog
    always @(posedge i_clk) begin
        t_eased_word exp_w;
        if (i_rst_n) begin
            if ((o_valid && i_ready) || (i_valid && o_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (o_valid && i_ready) begin
                if (pending_eased.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected word: eased=%0d ok=%0b", o_eased, o_ok);
                    end
                end else begin
                    exp_w = pending_eased.pop_front();
                    if (exp_w.eased !== o_eased || exp_w.ok !== o_ok) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: exp eased=%0d ok=%0b, got eased=%0d ok=%0b",
                                     exp_w.eased, exp_w.ok, o_eased, o_ok);
                        end
                    end
                end
            end
            if (i_valid && o_ready) begin
                pending_eased.push_back(predict_eased(i_progress));
            end
            if (quiet_cycles >= WD_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // receiver with random stalls and an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen   <= hold_seq;
            hold_cycles <= hold_len;
            i_ready     <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready     <= 1'b0;
        end else begin
            i_ready <= ($urandom % 100) >= recv_idle_pct;
        end
    end

    task automatic send_word(input logic [cbe_pkg::PX_W-1:0] prog);
        i_valid    <= 1'b1;
        i_progress <= prog;
        do @(posedge i_clk); while (!o_ready);
        if (($urandom % 100) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_eased.size() != 0) begin
            @(posedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic write_reg(input cbe_pkg::t_reg idx, input longint val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= cbe_pkg::PY_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            cbe_pkg::REG_C1X: ctl_c1x = val & 64'h1FFFF;
            cbe_pkg::REG_C1Y: ctl_c1y = val;
            cbe_pkg::REG_C2X: ctl_c2x = val & 64'h1FFFF;
            cbe_pkg::REG_C2Y: ctl_c2y = val;
            default: ;
        endcase
    endtask

    task automatic set_curve(input longint x1, input longint y1, input longint x2,
                             input longint y2);
        drain();
        write_reg(cbe_pkg::REG_C1X, x1);
        write_reg(cbe_pkg::REG_C1Y, y1);
        write_reg(cbe_pkg::REG_C2X, x2);
        write_reg(cbe_pkg::REG_C2Y, y2);
    endtask

    task automatic test_linear_ends();
        send_word(17'd0);
        send_word(17'd6);
        send_word(17'd7);
        send_word(17'd32768);
        send_word(17'd65529);
        send_word(17'd65530);
        send_word(17'd65536);
    endtask

    task automatic test_curve_shapes();
        set_curve(16384, 6554, 16384, 65536);
        send_word(17'd1000);
        send_word(17'd20000);
        send_word(17'd50000);
        set_curve(65537, 0, 65536, 65536);
        send_word(17'd30000);
        set_curve(0, 196608, 0, -131072);
        send_word(17'd100);
        send_word(17'd40000);
        set_curve(65536, -131072, 0, 196608);
        send_word(17'd10);
        send_word(17'd32768);
        send_word(17'd65000);
        set_curve(0, 0, 131071, 65536);
        send_word(17'd12345);
        set_curve(65536, 65536, 65536, 65536);
        send_word(17'd64000);
        send_word(17'd131071 & 17'h10000);
    endtask

    task automatic random_curve();
        longint x1, x2;
        x1 = ($urandom % 8 == 0) ? $urandom_range(0, 131071) : $urandom_range(0, 65536);
        x2 = ($urandom % 8 == 0) ? $urandom_range(0, 131071) : $urandom_range(0, 65536);
        if ($urandom % 6 == 0) begin
            set_curve(x1, x1, x2, x2);
        end else begin
            set_curve(x1, longint'($urandom_range(0, 327680)) - 131072, x2,
                      longint'($urandom_range(0, 327680)) - 131072);
        end
    endtask

    task automatic test_random(input int n_words, input int s_pct, input int r_pct);
        drain();
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < n_words; i++) begin
            if (i % 40 == 0) begin
                random_curve();
            end
            case ($urandom % 8)
                0:       send_word(cbe_pkg::PX_W'($urandom_range(0, 12)));
                1:       send_word(cbe_pkg::PX_W'($urandom_range(65524, 65536)));
                default: send_word(cbe_pkg::PX_W'($urandom_range(0, 65536)));
            endcase
        end
    endtask

    task automatic test_backpressure();
        set_curve(13107, 0, 39322, 65536);
        hold_len = 1500;
        hold_seq++;
        for (int i = 0; i < 8; i++) begin
            send_word(cbe_pkg::PX_W'($urandom_range(0, 65536)));
        end
    endtask

    initial begin
        ctl_c1x = 0;
        ctl_c1y = 0;
        ctl_c2x = ONE_L;
        ctl_c2y = ONE_L;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_linear_ends();
        test_curve_shapes();
        test_backpressure();
        test_random(640, 14, 79);
        test_random(640, 79, 14);
        test_random(640, 0, 0);
        drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_eased.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
